@@ src/mcnd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcnd_pkg
// Shared types and constants for the non-decreasing minimum cost DP core.
// ----------------------------------------------------------------------------
package mcnd_pkg;

    localparam int MAX_VALUE_DEF = 1023;
    localparam int COST_BITS_DEF = 23;
    localparam int SAMPLE_W      = 10;
    localparam int OUT_W         = 23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;    // latch a new item
        logic issue;     // read one row entry this cycle
        logic load_out;  // move the final cost into the output register
    } cmd_t;

endpackage
// ----------------------------------------------------------------------------

@@ src/mcnd_ram.sv @@
// ----------------------------------------------------------------------------
// mcnd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
// ----------------------------------------------------------------------------

@@ src/mcnd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcnd_ctrl
// Sequencer: accepts an item, sweeps the row index, publishes the result.
// ----------------------------------------------------------------------------
module mcnd_ctrl
    import mcnd_pkg::*;
#(
    parameter int MAX_VALUE = MAX_VALUE_DEF,
    parameter int IDX_W     = $clog2(MAX_VALUE + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] rd_idx
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_idx;

    assign last_idx = (rd_idx_reg == IDX_W'(MAX_VALUE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    rd_idx_next = '0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.issue   = 1'b1;
                rd_idx_next = rd_idx_reg + 1'b1;
                if (last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign rd_idx    = rd_idx_reg;

endmodule
// ----------------------------------------------------------------------------

@@ src/mcnd_dp.sv @@
// ----------------------------------------------------------------------------
// mcnd_dp
// Datapath: cost row RAM, one read-modify-write per cycle, running minimum.
// ----------------------------------------------------------------------------
module mcnd_dp
    import mcnd_pkg::*;
#(
    parameter int MAX_VALUE = MAX_VALUE_DEF,
    parameter int COST_BITS = COST_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_VALUE + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [IDX_W-1:0]    rd_idx,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic                start_sequence,
    output logic [OUT_W-1:0]    min_total_cost
);

    localparam int DIFF_W = (IDX_W > SAMPLE_W) ? IDX_W : SAMPLE_W;
    localparam int EXT_W  = (DIFF_W > COST_BITS) ? DIFF_W : COST_BITS;
    localparam int OW     = (COST_BITS > OUT_W) ? COST_BITS : OUT_W;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;
    localparam logic [OUT_W-1:0]     OUT_MAX  = '1;

    logic [SAMPLE_W-1:0]  sample_reg;
    logic                 fresh_reg;
    logic                 row_valid_reg;
    logic                 pipe_valid_reg;
    logic [IDX_W-1:0]     pipe_idx_reg;
    logic [COST_BITS-1:0] run_reg, run_next;
    logic [OUT_W-1:0]     out_data_reg;

    logic [COST_BITS-1:0] rd_data;
    logic [DIFF_W-1:0]    a_ext, v_ext, diff;
    logic [EXT_W-1:0]     diff_ext;
    logic [COST_BITS-1:0] diff_sat, old_cost, term;
    logic [COST_BITS:0]   sum;
    logic [OW-1:0]        run_wide;

    mcnd_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (MAX_VALUE + 1)
    ) u_row (
        .clk     (clk),
        .wr_en   (pipe_valid_reg),
        .wr_addr (pipe_idx_reg),
        .wr_data (run_next),
        .rd_en   (cmd.issue),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    // cost term for candidate v: saturated |a - v| plus the old row entry
    always_comb
    begin
        a_ext    = DIFF_W'(sample_reg);
        v_ext    = DIFF_W'(pipe_idx_reg);
        diff     = (a_ext > v_ext) ? (a_ext - v_ext) : (v_ext - a_ext);
        diff_ext = EXT_W'(diff);
        diff_sat = (diff_ext > EXT_W'(COST_MAX)) ? COST_MAX : diff_ext[COST_BITS-1:0];
        old_cost = fresh_reg ? '0 : rd_data;
        sum      = {1'b0, diff_sat} + {1'b0, old_cost};
        term     = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
        run_next = run_reg;
        if (pipe_valid_reg && ((pipe_idx_reg == '0) || (term < run_reg)))
        begin
            run_next = term;
        end
        run_wide = OW'(run_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= 1'b0;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= cmd.issue;
            if (cmd.accept)
            begin
                row_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= rd_idx;
        run_reg      <= run_next;
        if (cmd.accept)
        begin
            sample_reg <= sample_value;
            fresh_reg  <= start_sequence || !row_valid_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= (run_wide > OW'(OUT_MAX)) ? OUT_MAX : run_wide[OUT_W-1:0];
        end
    end

    assign min_total_cost = out_data_reg;

endmodule
// ----------------------------------------------------------------------------

@@ src/min_cost_nondecreasing_dp_core.sv @@
// ----------------------------------------------------------------------------
// min_cost_nondecreasing_dp_core
// The core takes a new item only after the previous one has swept the whole row
// and its result is in the output register; the row RAM's single read and
// single write port carry one entry per cycle, so the sweep sets the pace.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; clears the sequencer and the row-valid flag.
// The row RAM needs no clearing pass: the first item after reset reads zeros.
// ----------------------------------------------------------------------------
module min_cost_nondecreasing_dp_core
    import mcnd_pkg::*;
#(
    parameter int MAX_VALUE = MAX_VALUE_DEF,
    parameter int COST_BITS = COST_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic                start_sequence,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    min_total_cost
);

    localparam int IDX_W = $clog2(MAX_VALUE + 1);

    // Controller drives the datapath through one command bundle and
    // the read index; the datapath holds the index in a register for the write side.
    cmd_t             cmd;
    logic [IDX_W-1:0] rd_idx;

    // Sequencer: idle -> sweep all candidates -> drain last write -> publish.
    mcnd_ctrl #(
        .MAX_VALUE (MAX_VALUE),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .rd_idx    (rd_idx)
    );

    // Row update: row[v] = min(row[v-1], sat(|a - v| + row[v])), carried
    // in a running-minimum register; the entry at v = 0 takes the term alone.
    mcnd_dp #(
        .MAX_VALUE (MAX_VALUE),
        .COST_BITS (COST_BITS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_idx         (rd_idx),
        .sample_value   (sample_value),
        .start_sequence (start_sequence),
        .min_total_cost (min_total_cost)
    );

endmodule
// ----------------------------------------------------------------------------

@@ src/mcnd_checker.sv @@
// ----------------------------------------------------------------------------
// mcnd_checker
// Port-level checks on the DP core's handshake sequencing.
// ----------------------------------------------------------------------------
module mcnd_checker
    import mcnd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [SAMPLE_W-1:0] sample_value,
    input logic                start_sequence,
    input logic                out_valid,
    input logic                out_ready,
    input logic [OUT_W-1:0]    min_total_cost
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_total_cost))
        else $error("result changed or dropped while stalled");

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready during sweep");

    // no result can appear the cycle after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised without a sweep");

    // publishing a result returns the core to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("core not idle after publishing a result");

endmodule

bind min_cost_nondecreasing_dp_core mcnd_checker u_mcnd_checker (.*);
// ----------------------------------------------------------------------------

@@ verif/min_cost_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_cost_checker
// Watches both channels of the DP core. Keeps its own cost row, predicts the
// cost of every accepted item and compares it with the returned results in
// order.
// ----------------------------------------------------------------------------
module min_cost_checker
    import mcnd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic                start_sequence,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [OUT_W-1:0]    min_total_cost,
    output int                  mismatch_count,
    output int                  expected_count
);

    localparam int    ROW_LAST  = MAX_VALUE_DEF;
    localparam longint COST_CEIL = (longint'(1) << COST_BITS_DEF) - 1;
    localparam longint OUT_CEIL  = (longint'(1) << OUT_W) - 1;

    longint           cost_row [0:ROW_LAST];
    logic             row_valid;
    logic [OUT_W-1:0] expected_costs [$];
    logic [OUT_W-1:0] oldest_cost;
    int               fail_total;

    // One sweep over all candidate final values; a fresh row reads as zeros.
    function automatic logic [OUT_W-1:0] sweep_cost_row(
        input logic [SAMPLE_W-1:0] sample,
        input logic                fresh
    );
        longint a;
        longint v;
        longint diff;
        longint prior;
        longint term;
        longint run_min;
        a       = longint'(sample);
        run_min = 0;
        for (v = 0; v <= ROW_LAST; v++)
        begin
            diff  = (a > v) ? (a - v) : (v - a);
            prior = fresh ? 0 : cost_row[v];
            term  = diff + prior;
            if (term > COST_CEIL)
                term = COST_CEIL;
            if (v == 0 || term < run_min)
                run_min = term;
            cost_row[v] = run_min;
        end
        return (run_min > OUT_CEIL) ? OUT_CEIL[OUT_W-1:0] : run_min[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid = 1'b0;
            expected_costs.delete();
            fail_total = 0;
            mismatch_count <= 0;
            expected_count <= 0;
        end
        else
        begin
            // Check results before queuing a new prediction: a result can
            // never belong to the item taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_costs.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, min_total_cost);
                end
                else
                begin
                    oldest_cost = expected_costs.pop_front();
                    if (oldest_cost !== min_total_cost)
                    begin
                        fail_total++;
                        $display("%0t: min_total_cost mismatch, expected %0d, actual %0d",
                                 $time, oldest_cost, min_total_cost);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_costs.push_back(
                    sweep_cost_row(sample_value, start_sequence || !row_valid));
                row_valid = 1'b1;
            end
            mismatch_count <= fail_total;
            expected_count <= expected_costs.size();
        end
    end

endmodule
// ----------------------------------------------------------------------------

@@ verif/tb_min_cost_nondecreasing_dp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_cost_nondecreasing_dp_core
// Drives the DP core with short directed sequences and then with random
// sequences of varied shape, under several idle and stall patterns on both
// channels. The checker beside the core predicts every cost and reports
// mismatches; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_min_cost_nondecreasing_dp_core;
    import mcnd_pkg::*;

    localparam int ITEM_TARGET  = 580;
    localparam int DRAIN_CYCLES = MAX_VALUE_DEF + 17;
    localparam int SAMPLE_TOP   = (1 << SAMPLE_W) - 1;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample_value   = '0;
    logic                start_sequence = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [OUT_W-1:0]    min_total_cost;

    int mismatch_count;
    int expected_count;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int idle_pct   = 0;
    int stall_pct  = 0;
    int stall_hold = 0;
    int items_sent = 0;

    always #4 clk = ~clk;

    min_cost_nondecreasing_dp_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .start_sequence (start_sequence),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .min_total_cost (min_total_cost)
    );

    min_cost_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .start_sequence (start_sequence),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .min_total_cost (min_total_cost),
        .mismatch_count (mismatch_count),
        .expected_count (expected_count)
    );

    // Receiver: stall at random per cycle, and now and then hold off for a
    // long stretch so the held result sits across every part of the next sweep.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_hold > 0)
        begin
            stall_hold--;
            out_ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 399) == 0)
        begin
            stall_hold = $urandom_range(1, 1500);
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offer one item and hold it until the core takes it. Entered and left
    // right after a rising edge, so valid gets one assignment per step and
    // stays high when the next item follows at once.
    task automatic push_item(input logic [SAMPLE_W-1:0] value, input logic first);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 11) == 0)
            gap = $urandom_range(1, 1100);
        while (gap == 0 && $urandom_range(0, 99) < idle_pct)
            gap++;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_value   <= value;
        start_sequence <= first;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Pick the next element of a sequence according to its shape.
    function automatic int next_sample(input int shape, input int prev);
        int value;
        case (shape)
            0: value = $urandom_range(0, SAMPLE_TOP);
            1: value = ($urandom_range(0, 9) == 0) ? prev - $urandom_range(0, 200)
                                                   : prev + $urandom_range(0, 40);
            2: value = prev - $urandom_range(0, 120);
            3: value = 512 + $urandom_range(0, 30) - 15;
            default: value = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
        endcase
        if (value < 0)
            value = 0;
        if (value > SAMPLE_TOP)
            value = SAMPLE_TOP;
        return value;
    endfunction

    // Advance through random sequences until the item count reaches limit.
    task automatic run_sequences(input int limit);
        int len;
        int shape;
        int prev;
        int i;
        bit first;
        while (items_sent < limit)
        begin
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 30);
            shape = $urandom_range(0, 4);
            prev  = (shape == 2) ? $urandom_range(700, SAMPLE_TOP)
                                 : $urandom_range(0, SAMPLE_TOP);
            for (i = 0; i < len && items_sent < limit; i++)
            begin
                prev = next_sample(shape, prev);
                // Mostly a clean start flag on the first element only; drop a
                // stray flag mid-sequence or a missing one now and then.
                first = (i == 0);
                if ($urandom_range(0, 19) == 0)
                    first = 1'($urandom_range(0, 1));
                push_item(prev[SAMPLE_W-1:0], first);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. The first item after reset arrives with
        // the start flag low and must still see a zero row.
        push_item(10'd700, 1'b0);
        push_item(10'd0,   1'b0);
        push_item(10'd1023, 1'b0);
        push_item(10'd0,   1'b0);
        push_item(10'd1023, 1'b0);
        // Alternating bit patterns, both start flag values.
        push_item(10'h155, 1'b1);
        push_item(10'h2AA, 1'b0);
        push_item(10'd512, 1'b0);
        push_item(10'd511, 1'b0);
        // Highs followed by lows: cost grows by the full range per pair.
        push_item(10'd1023, 1'b1);
        push_item(10'd1023, 1'b0);
        push_item(10'd1023, 1'b0);
        push_item(10'd0,   1'b0);
        push_item(10'd0,   1'b0);
        push_item(10'd0,   1'b0);
        push_item(10'd0,   1'b1);
        push_item(10'd1,   1'b0);
        push_item(10'd1022, 1'b0);
        // One-item sequences back to back.
        push_item(10'd0,   1'b1);
        push_item(10'd5,   1'b1);

        // Random part in four idling phases.
        idle_pct  = 0;
        stall_pct = 0;
        run_sequences(items_sent + (ITEM_TARGET - items_sent) / 4);
        idle_pct  = 65;
        stall_pct = 0;
        run_sequences(items_sent + (ITEM_TARGET - items_sent) / 3);
        idle_pct  = 0;
        stall_pct = 65;
        run_sequences(items_sent + (ITEM_TARGET - items_sent) / 2);
        idle_pct  = 7;
        stall_pct = 7;
        run_sequences(ITEM_TARGET);

        in_valid <= 1'b0;
        // Let every outstanding result come back, then give the core a full
        // sweep to show any stray result.
        do @(posedge clk); while (expected_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard: several times the slowest correct run.
    initial
    begin
        #100000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
// ----------------------------------------------------------------------------
